>>> sv/tti_pkg.sv
// Shared constants, payload types and arithmetic widths of the triangle intersection test.
package tti_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int VTX_W       = 48;
    localparam int OUT_W       = 3;

    localparam int E_W   = COORD_WIDTH + 1;
    localparam int N_W   = 2 * COORD_WIDTH + 2;
    localparam int PD_W  = 3 * COORD_WIDTH + 3;
    localparam int D_W   = 3 * COORD_WIDTH + 5;
    localparam int Q_W   = D_W + 1;
    localparam int NUM_W = 4 * COORD_WIDTH + 6;

    localparam int CA    = (NUM_W + 2) / 3;
    localparam int MA_W  = 3 * CA;
    localparam int CB    = (Q_W + 1) / 2;
    localparam int MB_W  = 2 * CB;
    localparam int MP_W  = MA_W + MB_W + 1;
    localparam int X_W   = MP_W + 1;

    localparam logic [OUT_W-1:0] OC_A_SIDE   = 3'd0;
    localparam logic [OUT_W-1:0] OC_B_SIDE   = 3'd1;
    localparam logic [OUT_W-1:0] OC_OVERLAP  = 3'd2;
    localparam logic [OUT_W-1:0] OC_DISJOINT = 3'd3;
    localparam logic [OUT_W-1:0] OC_COPLANAR = 3'd4;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [E_W-1:0]         t_edge;
    typedef logic signed [N_W-1:0]         t_nrm;
    typedef logic signed [PD_W-1:0]        t_pd;
    typedef logic signed [D_W-1:0]         t_dst;
    typedef logic signed [Q_W-1:0]         t_q;
    typedef logic signed [NUM_W-1:0]       t_num;
    typedef logic signed [MA_W-1:0]        t_ma;
    typedef logic signed [MB_W-1:0]        t_mb;
    typedef logic [MA_W+MB_W-1:0]          t_msum;
    typedef logic signed [MP_W-1:0]        t_mp;
    typedef logic signed [X_W-1:0]         t_x;

    typedef struct packed {
        logic [VTX_W-1:0] tri_a_vertex0;
        logic [VTX_W-1:0] tri_a_vertex1;
        logic [VTX_W-1:0] tri_a_vertex2;
        logic [VTX_W-1:0] tri_b_vertex0;
        logic [VTX_W-1:0] tri_b_vertex1;
        logic [VTX_W-1:0] tri_b_vertex2;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] outcome;
    } t_out;

endpackage

>>> sv/tti_mul.sv
// Four-stage signed multiplier built from narrow partial products.
module tti_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  tti_pkg::t_ma i_a,
    input  tti_pkg::t_mb i_b,
    output tti_pkg::t_mp o_p
);

    logic [tti_pkg::MA_W-1:0]            r_ma, n_ma;
    logic [tti_pkg::MB_W-1:0]            r_mb, n_mb;
    logic                                r_neg1, r_neg2, r_neg3;
    logic [tti_pkg::CA+tti_pkg::CB-1:0]  r_pp [3][2];
    tti_pkg::t_msum                      r_sum, n_sum;
    tti_pkg::t_mp                        r_p;

    always_comb begin
        n_ma = i_a[tti_pkg::MA_W-1] ? (~i_a + 1'b1) : i_a;
        n_mb = i_b[tti_pkg::MB_W-1] ? (~i_b + 1'b1) : i_b;
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) begin
                n_sum = n_sum + (tti_pkg::t_msum'(r_pp[i][j])
                                 << (i * tti_pkg::CA + j * tti_pkg::CB));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_neg1 <= i_a[tti_pkg::MA_W-1] ^ i_b[tti_pkg::MB_W-1];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r_pp[i][j] <= r_ma[i*tti_pkg::CA +: tti_pkg::CA]
                                * r_mb[j*tti_pkg::CB +: tti_pkg::CB];
                end
            end
            r_neg2 <= r_neg1;
            r_sum  <= n_sum;
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? -tti_pkg::t_mp'(r_sum) : tti_pkg::t_mp'(r_sum);
        end
    end

    assign o_p = r_p;

endmodule

>>> sv/triangle_triangle_intersect.sv
// Top level: pipelined exact triangle/triangle intersection test.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_ready  | i_data (tti_pkg::t_in, six packed vertices)
//  out     | output    | o_valid / i_ready  | o_data (tti_pkg::t_out, hit and outcome)
//
//  One triangle pair per cycle while the output register is not stalled.
//  Pipeline depth is set by the chain of three four-stage wide multipliers (direction,
//  interval numerators, endpoint cross products) plus the plane and distance stages.
//  Synchronous reset clears all valid bits; no clearing pass.
//  A stalled output register freezes every stage through one shared enable.
module triangle_triangle_intersect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tti_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tti_pkg::t_out o_data
);

    typedef struct packed {
        logic                      itv;
        logic [tti_pkg::OUT_W-1:0] oc;
        logic [1:0]                la;
        logic [1:0]                lb;
    } t_ctl;

    function automatic logic [1:0] f_lone(input logic [2:0] p, input logic [2:0] n);
        logic [2:0] nz;
        nz = p | n;
        if ((p[0] & p[1]) | (n[0] & n[1]))                 f_lone = 2'd2;
        else if ((p[0] & p[2]) | (n[0] & n[2]))            f_lone = 2'd1;
        else if ((p[1] & p[2]) | (n[1] & n[2]) | nz[0])    f_lone = 2'd0;
        else if (nz[1])                                    f_lone = 2'd1;
        else                                               f_lone = 2'd2;
    endfunction

    function automatic logic [1:0] f_nxt(input logic [1:0] l);
        f_nxt = (l == 2'd2) ? 2'd0 : l + 2'd1;
    endfunction

    logic en;
    logic r_vld [1:22];
    logic r_ov;
    tti_pkg::t_out r_out, n_out;

    logic [tti_pkg::VTX_W-1:0] w_vtx [2][3];
    tti_pkg::t_coord w_v [2][3][3];

    tti_pkg::t_coord r_v    [1:11][2][3][3];
    tti_pkg::t_edge  r1_e   [2][2][3];
    tti_pkg::t_edge  r_p    [1:3][2][3][3];
    tti_pkg::t_nrm   r2_np  [2][3][2];
    tti_pkg::t_nrm   r_n    [3:5][2][3];
    tti_pkg::t_pd    r4_dp  [2][3][3];
    tti_pkg::t_dst   r_d    [5:11][2][3];
    t_ctl            r_ctl  [6:22];
    t_ctl            n6_ctl;
    logic [2:0]      w_pos [2], w_neg [2], w_nz [2];

    tti_pkg::t_mp    w_dp   [3][2];
    logic [tti_pkg::X_W-1:0] r10_ad [3];
    tti_pkg::t_x     w_dx   [3];
    logic [1:0]      r11_axis;

    tti_pkg::t_coord r12_pl [2];
    tti_pkg::t_coord r12_pt [2][2];
    tti_pkg::t_dst   r12_dl [2];
    tti_pkg::t_dst   r12_di [2][2];
    tti_pkg::t_q     r_q    [12:16][2][2];
    tti_pkg::t_mp    w_ip0  [2][2];
    tti_pkg::t_mp    w_ip1  [2][2];

    tti_pkg::t_num   r17_num [2][2];
    tti_pkg::t_q     r17_den [2][2];
    tti_pkg::t_mp    w_sw   [2][2];
    tti_pkg::t_mp    w_u    [2][2];
    tti_pkg::t_mp    w_w    [2][2];

    logic            r22_swap [2];
    logic            r22_lab  [2][2];
    logic            r22_lba  [2][2];

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    assign w_vtx[0][0] = i_data.tri_a_vertex0;
    assign w_vtx[0][1] = i_data.tri_a_vertex1;
    assign w_vtx[0][2] = i_data.tri_a_vertex2;
    assign w_vtx[1][0] = i_data.tri_b_vertex0;
    assign w_vtx[1][1] = i_data.tri_b_vertex1;
    assign w_vtx[1][2] = i_data.tri_b_vertex2;

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    w_v[t][k][c] = tti_pkg::t_coord'(
                        w_vtx[t][k][c*tti_pkg::COORD_WIDTH +: tti_pkg::COORD_WIDTH]);
                end
            end
        end
    end

    // plane side classification and lone vertex
    always_comb begin
        for (int t = 0; t < 2; t++) begin
            for (int k = 0; k < 3; k++) begin
                w_neg[t][k] = r_d[5][t][k][tti_pkg::D_W-1];
                w_nz[t][k]  = |r_d[5][t][k];
                w_pos[t][k] = w_nz[t][k] & ~w_neg[t][k];
            end
        end
        n6_ctl.itv = 1'b0;
        n6_ctl.la  = f_lone(w_pos[0], w_neg[0]);
        n6_ctl.lb  = f_lone(w_pos[1], w_neg[1]);
        if ((&w_pos[0]) | (&w_neg[0])) begin
            n6_ctl.oc = tti_pkg::OC_A_SIDE;
        end else if ((&w_pos[1]) | (&w_neg[1])) begin
            n6_ctl.oc = tti_pkg::OC_B_SIDE;
        end else if (~|w_nz[0] | ~|w_nz[1]) begin
            n6_ctl.oc = tti_pkg::OC_COPLANAR;
        end else begin
            n6_ctl.oc  = tti_pkg::OC_OVERLAP;
            n6_ctl.itv = 1'b1;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_dx[c] = tti_pkg::t_x'(w_dp[c][0]) - tti_pkg::t_x'(w_dp[c][1]);
        end
    end

    genvar gc, gt, ge;
    generate
        for (gc = 0; gc < 3; gc++) begin : g_dir
            tti_mul u_mul0 (
                .i_clk (i_clk), .i_en (en),
                .i_a   (tti_pkg::t_ma'(r_n[5][0][(gc+1)%3])),
                .i_b   (tti_pkg::t_mb'(r_n[5][1][(gc+2)%3])),
                .o_p   (w_dp[gc][0])
            );
            tti_mul u_mul1 (
                .i_clk (i_clk), .i_en (en),
                .i_a   (tti_pkg::t_ma'(r_n[5][0][(gc+2)%3])),
                .i_b   (tti_pkg::t_mb'(r_n[5][1][(gc+1)%3])),
                .o_p   (w_dp[gc][1])
            );
        end
        for (gt = 0; gt < 2; gt++) begin : g_tri
            for (ge = 0; ge < 2; ge++) begin : g_end
                tti_mul u_mul_pd (
                    .i_clk (i_clk), .i_en (en),
                    .i_a   (tti_pkg::t_ma'(r12_di[gt][ge])),
                    .i_b   (tti_pkg::t_mb'(r12_pl[gt])),
                    .o_p   (w_ip0[gt][ge])
                );
                tti_mul u_mul_td (
                    .i_clk (i_clk), .i_en (en),
                    .i_a   (tti_pkg::t_ma'(r12_dl[gt])),
                    .i_b   (tti_pkg::t_mb'(r12_pt[gt][ge])),
                    .o_p   (w_ip1[gt][ge])
                );
                tti_mul u_mul_sw (
                    .i_clk (i_clk), .i_en (en),
                    .i_a   (tti_pkg::t_ma'(r17_num[gt][1-ge])),
                    .i_b   (tti_pkg::t_mb'(r17_den[gt][ge])),
                    .o_p   (w_sw[gt][ge])
                );
                // gt indexes A endpoint, ge indexes B endpoint
                tti_mul u_mul_u (
                    .i_clk (i_clk), .i_en (en),
                    .i_a   (tti_pkg::t_ma'(r17_num[0][gt])),
                    .i_b   (tti_pkg::t_mb'(r17_den[1][ge])),
                    .o_p   (w_u[gt][ge])
                );
                tti_mul u_mul_w (
                    .i_clk (i_clk), .i_en (en),
                    .i_a   (tti_pkg::t_ma'(r17_num[1][ge])),
                    .i_b   (tti_pkg::t_mb'(r17_den[0][gt])),
                    .o_p   (w_w[gt][ge])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            // edges, offsets from the other plane's base vertex
            for (int t = 0; t < 2; t++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_e[t][0][c] <= tti_pkg::t_edge'(w_v[t][1][c])
                                   - tti_pkg::t_edge'(w_v[t][0][c]);
                    r1_e[t][1][c] <= tti_pkg::t_edge'(w_v[t][2][c])
                                   - tti_pkg::t_edge'(w_v[t][0][c]);
                    for (int k = 0; k < 3; k++) begin
                        r_v[1][t][k][c] <= w_v[t][k][c];
                        r_p[1][t][k][c] <= tti_pkg::t_edge'(w_v[t][k][c])
                                         - tti_pkg::t_edge'(w_v[1-t][0][c]);
                    end
                end
            end
            for (int s = 2; s <= 11; s++) r_v[s] <= r_v[s-1];
            for (int s = 2; s <= 3; s++)  r_p[s] <= r_p[s-1];
            for (int t = 0; t < 2; t++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_np[t][c][0] <= tti_pkg::t_nrm'(r1_e[t][0][(c+1)%3]
                                                     * r1_e[t][1][(c+2)%3]);
                    r2_np[t][c][1] <= tti_pkg::t_nrm'(r1_e[t][0][(c+2)%3]
                                                     * r1_e[t][1][(c+1)%3]);
                    r_n[3][t][c]   <= r2_np[t][c][0] - r2_np[t][c][1];
                end
            end
            for (int s = 4; s <= 5; s++) r_n[s] <= r_n[s-1];
            for (int t = 0; t < 2; t++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        r4_dp[t][k][j] <= tti_pkg::t_pd'(r_n[3][1-t][j] * r_p[3][t][k][j]);
                    end
                    r_d[5][t][k] <= tti_pkg::t_dst'(r4_dp[t][k][0])
                                  + tti_pkg::t_dst'(r4_dp[t][k][1])
                                  + tti_pkg::t_dst'(r4_dp[t][k][2]);
                end
            end
            for (int s = 6; s <= 11; s++) r_d[s] <= r_d[s-1];
            r_ctl[6] <= n6_ctl;
            for (int s = 7; s <= 22; s++) r_ctl[s] <= r_ctl[s-1];

            // dominant axis of the line direction
            for (int c = 0; c < 3; c++) begin
                r10_ad[c] <= w_dx[c][tti_pkg::X_W-1] ? (~w_dx[c] + 1'b1) : w_dx[c];
            end
            if (r10_ad[0] >= r10_ad[1] && r10_ad[0] >= r10_ad[2]) r11_axis <= 2'd0;
            else if (r10_ad[1] >= r10_ad[2])                        r11_axis <= 2'd1;
            else                                                    r11_axis <= 2'd2;

            // interval endpoint operands
            for (int t = 0; t < 2; t++) begin
                logic [1:0] l, ie;
                l = (t == 0) ? r_ctl[11].la : r_ctl[11].lb;
                r12_pl[t] <= r_v[11][t][l][r11_axis];
                r12_dl[t] <= r_d[11][t][l];
                for (int e = 0; e < 2; e++) begin
                    ie = (e == 0) ? f_nxt(l) : f_nxt(f_nxt(l));
                    r12_pt[t][e]   <= r_v[11][t][ie][r11_axis];
                    r12_di[t][e]   <= r_d[11][t][ie];
                    r_q[12][t][e]  <= tti_pkg::t_q'(r_d[11][t][ie])
                                    - tti_pkg::t_q'(r_d[11][t][l]);
                end
            end
            for (int s = 13; s <= 16; s++) r_q[s] <= r_q[s-1];

            for (int t = 0; t < 2; t++) begin
                for (int e = 0; e < 2; e++) begin
                    r17_num[t][e] <= r_q[16][t][e][tti_pkg::Q_W-1]
                                   ? tti_pkg::t_num'(w_ip1[t][e] - w_ip0[t][e])
                                   : tti_pkg::t_num'(w_ip0[t][e] - w_ip1[t][e]);
                    r17_den[t][e] <= r_q[16][t][e][tti_pkg::Q_W-1]
                                   ? -r_q[16][t][e] : r_q[16][t][e];
                end
            end

            for (int t = 0; t < 2; t++) begin
                r22_swap[t] <= w_sw[t][0] < w_sw[t][1];
                for (int e = 0; e < 2; e++) begin
                    r22_lab[t][e] <= w_u[t][e] < w_w[t][e];
                    r22_lba[t][e] <= w_w[t][e] < w_u[t][e];
                end
            end

            r_out <= n_out;
        end
    end

    always_comb begin
        logic amin, amax, bmin, bmax, disj;
        amin = r22_swap[0];
        amax = ~r22_swap[0];
        bmin = r22_swap[1];
        bmax = ~r22_swap[1];
        disj = r22_lab[amax][bmin] | r22_lba[amin][bmax];
        if (r_ctl[22].itv) n_out.outcome = disj ? tti_pkg::OC_DISJOINT : tti_pkg::OC_OVERLAP;
        else               n_out.outcome = r_ctl[22].oc;
        n_out.hit = (n_out.outcome == tti_pkg::OC_OVERLAP)
                 || (n_out.outcome == tti_pkg::OC_COPLANAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 22; s++) r_vld[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_valid;
            for (int s = 2; s <= 22; s++) r_vld[s] <= r_vld[s-1];
            r_ov <= r_vld[22];
        end
    end

    a_hit_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.hit == ((o_data.outcome == tti_pkg::OC_OVERLAP)
                                 || (o_data.outcome == tti_pkg::OC_COPLANAR))))
        else $error("hit disagrees with outcome");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

    a_stall_freeze: assert property (@(posedge i_clk)
        (i_rst_n && !o_ready) |=> ($stable(r_vld[22]) && $stable(r_vld[12]) && $stable(r_ov)))
        else $error("pipeline moved during stall");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[12] && r_ctl[12].itv) |->
            (r_q[12][0][0] != 0 && r_q[12][0][1] != 0
             && r_q[12][1][0] != 0 && r_q[12][1][1] != 0))
        else $error("zero interval denominator");

endmodule
